/* hdl/swo_acc_pkg.sv */
// package: constants, payload types and codes shared by the occupancy accumulator
`timescale 1ns / 1ps
package swo_acc_pkg;

  localparam int MAP_CELLS_MAX   = 1048576;
  localparam int POINTS_PER_SCAN = 1024;
  localparam int LOG_SCANS       = 128;
  localparam int LOG_DEPTH       = LOG_SCANS * POINTS_PER_SCAN;
  localparam int IDX_W           = $clog2(MAP_CELLS_MAX);
  localparam int POS_W           = $clog2(POINTS_PER_SCAN);
  localparam int SLOT_W          = $clog2(LOG_SCANS);
  localparam int LEN_W           = POS_W + 1;
  localparam int LOG_AW          = SLOT_W + POS_W;

  localparam logic [7:0] HIT_STEP  = 8'd1;
  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam logic [7:0] OCCUPIED  = 8'd200;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [2:0] REG_MAP_WIDTH = 3'd0;
  localparam logic [2:0] REG_MAP_CELLS = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
  localparam logic [2:0] REG_CPM       = 3'd4;
  localparam logic [2:0] REG_WINDOW    = 3'd5;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_t;

  typedef struct packed {
    logic        in_range;
    logic [19:0] cell_index;
    logic [7:0]  cell_count;
    logic [7:0]  occupancy;
    logic [10:0] expired_hits;
    logic        log_full;
    logic [6:0]  scans_held;
  } out_t;

  typedef struct packed {
    logic [1:0]       action;
    logic             in_range;
    logic [IDX_W-1:0] cell_index;
  } cls_t;

  typedef struct packed {
    logic [12:0]        map_width;
    logic [20:0]        map_cells;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [15:0]        cells_per_meter;
    logic [6:0]         window_scans;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

/* hdl/swo_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module swo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/swo_front.sv */
// front end: takes items, maps points to linear cell indices and classifies them
`timescale 1ns / 1ps
module swo_front import swo_acc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic accept,
  input  in_t  item,
  output logic ready,
  output logic q_push,
  output cls_t q_item,
  input  logic q_full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SUB  = 3'd1;
  localparam logic [2:0] F_MUL  = 3'd2;
  localparam logic [2:0] F_TRN  = 3'd3;
  localparam logic [2:0] F_LIN  = 3'd4;
  localparam logic [2:0] F_SUM  = 3'd5;
  localparam logic [2:0] F_OUT  = 3'd6;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [1:0]         action;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [49:0] prx;
  logic signed [49:0] pry;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [47:0] lp;
  logic signed [48:0] lin;
  logic [20:0]        bound;
  logic               inr;
  logic               locating;

  assign bound    = (cfg.map_cells > 21'(MAP_CELLS_MAX)) ? 21'(MAP_CELLS_MAX) : cfg.map_cells;
  assign inr      = !lin[48] && (lin[47:0] < 48'(bound));
  assign locating = (action == ACT_POINT) || (action == ACT_QUERY);
  assign ready    = (state == F_IDLE);
  assign q_push   = (state == F_OUT) && !q_full;

  always_comb begin
    q_item.action     = action;
    q_item.in_range   = locating && inr;
    q_item.cell_index = (locating && inr) ? lin[IDX_W-1:0] : '0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (accept) state_next = F_SUB;
      F_SUB:   state_next = F_MUL;
      F_MUL:   state_next = F_TRN;
      F_TRN:   state_next = F_LIN;
      F_LIN:   state_next = F_SUM;
      F_SUM:   state_next = F_OUT;
      F_OUT:   if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      action <= item.action;
      px     <= item.point_x;
      py     <= item.point_y;
    end
    dx  <= $signed({px[31], px}) - $signed({cfg.origin_x[31], cfg.origin_x});
    dy  <= $signed({py[31], py}) - $signed({cfg.origin_y[31], cfg.origin_y});
    prx <= dx * $signed({1'b0, cfg.cells_per_meter});
    pry <= dy * $signed({1'b0, cfg.cells_per_meter});
    // truncate toward zero
    cx  <= 34'((prx + $signed({34'd0, {16{prx[49]}}})) >>> 16);
    cy  <= 34'((pry + $signed({34'd0, {16{pry[49]}}})) >>> 16);
    lp  <= $signed({1'b0, cfg.map_width}) * cy;
    lin <= 49'(lp) + 49'(cx);
  end

endmodule

/* hdl/swo_queue.sv */
// two-entry queue of classified items between front and back
`timescale 1ns / 1ps
module swo_queue import swo_acc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t wdata,
  output logic full,
  input  logic pop,
  output cls_t rdata,
  output logic empty
);

  cls_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

/* hdl/swo_back.sv */
// back end: hit-count updates, scan log, window expiry and result register
`timescale 1ns / 1ps
module swo_back import swo_acc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  cls_t       q_item,
  input  logic       q_empty,
  output logic       q_pop,
  output back_stat_t stat,
  output out_t       result,
  output logic       res_valid,
  input  logic       res_pop
);

  localparam logic [3:0] B_CLR    = 4'd0;
  localparam logic [3:0] B_IDLE   = 4'd1;
  localparam logic [3:0] B_RD     = 4'd2;
  localparam logic [3:0] B_RMW    = 4'd3;
  localparam logic [3:0] B_LEN_RD = 4'd4;
  localparam logic [3:0] B_LEN_W  = 4'd5;
  localparam logic [3:0] B_LOG_RD = 4'd6;
  localparam logic [3:0] B_LOG_W  = 4'd7;
  localparam logic [3:0] B_DEC    = 4'd8;
  localparam logic [3:0] B_FIN    = 4'd9;
  localparam logic [3:0] B_DONE   = 4'd10;

  localparam logic [SLOT_W-1:0] CAP = SLOT_W'(LOG_SCANS - 1);

  logic [3:0]        state;
  cls_t              cur;
  logic [IDX_W-1:0]  clr;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] queued;
  logic [LEN_W-1:0]  open_len;
  logic [LEN_W-1:0]  exp_len;
  logic [LEN_W-1:0]  pos;
  logic [IDX_W-1:0]  dec_addr;
  logic [7:0]        r_cnt;
  logic [7:0]        r_occ;
  logic [10:0]       r_exp;
  logic              r_full;

  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] open_slot;
  logic [SLOT_W-1:0] win;
  logic              start_exp;
  logic              end_exp;
  logic [7:0]        cnt_new;

  logic              cnt_we;
  logic [IDX_W-1:0]  cnt_waddr;
  logic [7:0]        cnt_wdata;
  logic [IDX_W-1:0]  cnt_raddr;
  logic [7:0]        cnt_rdata;
  logic              log_we;
  logic [IDX_W-1:0]  log_rdata;
  logic              len_we;
  logic [LEN_W-1:0]  len_rdata;

  assign slot_sum  = {1'b0, oldest} + {1'b0, queued};
  assign open_slot = (slot_sum >= (SLOT_W + 1)'(LOG_SCANS)) ?
                     SLOT_W'(slot_sum - (SLOT_W + 1)'(LOG_SCANS)) : slot_sum[SLOT_W-1:0];
  assign win       = (cfg.window_scans == 7'd0) ? SLOT_W'(1) : SLOT_W'(cfg.window_scans);
  assign start_exp = (queued != '0) && ((queued >= win) || (queued >= CAP));
  assign end_exp   = (queued >= CAP) && (queued != '0);
  assign cnt_new   = (cnt_rdata == COUNT_MAX) ? COUNT_MAX : cnt_rdata + HIT_STEP;

  assign q_pop         = (state == B_IDLE) && !q_empty && !res_valid;
  assign stat.clearing = (state == B_CLR);
  assign stat.busy     = (state != B_IDLE);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cur.cell_index;
    cnt_wdata = cnt_new;
    cnt_raddr = cur.cell_index;
    log_we    = 1'b0;
    len_we    = 1'b0;
    unique case (state)
      B_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr;
        cnt_wdata = '0;
      end
      B_RMW: begin
        if (cur.action == ACT_POINT && open_len < LEN_W'(POINTS_PER_SCAN)) begin
          cnt_we = 1'b1;
          log_we = 1'b1;
        end
      end
      B_LOG_W: cnt_raddr = log_rdata;
      B_DEC: begin
        cnt_waddr = dec_addr;
        cnt_wdata = cnt_rdata - 8'd1;
        cnt_we    = (cnt_rdata != 8'd0);
      end
      B_DONE: len_we = (cur.action == ACT_END);
      default: begin
      end
    endcase
  end

  swo_ram #(.WIDTH(8), .DEPTH(MAP_CELLS_MAX)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  swo_ram #(.WIDTH(IDX_W), .DEPTH(LOG_DEPTH)) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr ({open_slot, open_len[POS_W-1:0]}),
    .wdata (cur.cell_index),
    .raddr ({oldest, pos[POS_W-1:0]}),
    .rdata (log_rdata)
  );

  swo_ram #(.WIDTH(LEN_W), .DEPTH(LOG_SCANS)) u_lengths (
    .clk   (clk),
    .we    (len_we),
    .waddr (open_slot),
    .wdata (open_len),
    .raddr (oldest),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      clr       <= '0;
      oldest    <= '0;
      queued    <= '0;
      open_len  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop) res_valid <= 1'b0;
      unique case (state)
        B_CLR: begin
          clr <= clr + IDX_W'(1);
          if (clr == IDX_W'(MAP_CELLS_MAX - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_pop) begin
            cur    <= q_item;
            r_cnt  <= '0;
            r_occ  <= '0;
            r_exp  <= '0;
            r_full <= 1'b0;
            unique case (q_item.action)
              ACT_START: state <= start_exp ? B_LEN_RD : B_DONE;
              ACT_END:   state <= end_exp ? B_LEN_RD : B_DONE;
              default:   state <= q_item.in_range ? B_RD : B_DONE;
            endcase
          end
        end
        B_RD: state <= B_RMW;
        B_RMW: begin
          if (cur.action == ACT_POINT) begin
            if (open_len >= LEN_W'(POINTS_PER_SCAN)) begin
              r_full <= 1'b1;
              r_cnt  <= cnt_rdata;
            end else begin
              r_cnt    <= cnt_new;
              open_len <= open_len + LEN_W'(1);
            end
          end else begin
            r_cnt <= cnt_rdata;
            r_occ <= (cnt_rdata != 8'd0) ? OCCUPIED : 8'd0;
          end
          state <= B_DONE;
        end
        B_LEN_RD: state <= B_LEN_W;
        B_LEN_W: begin
          exp_len <= (len_rdata > LEN_W'(POINTS_PER_SCAN)) ? LEN_W'(POINTS_PER_SCAN) : len_rdata;
          pos     <= '0;
          state   <= (len_rdata == '0) ? B_FIN : B_LOG_RD;
        end
        B_LOG_RD: state <= B_LOG_W;
        B_LOG_W: begin
          dec_addr <= log_rdata;
          state    <= B_DEC;
        end
        B_DEC: begin
          pos   <= pos + LEN_W'(1);
          state <= (pos + LEN_W'(1) == exp_len) ? B_FIN : B_LOG_RD;
        end
        B_FIN: begin
          r_exp  <= 11'(exp_len);
          oldest <= (oldest == CAP) ? '0 : oldest + SLOT_W'(1);
          queued <= queued - SLOT_W'(1);
          state  <= B_DONE;
        end
        B_DONE: begin
          if (cur.action == ACT_END) begin
            queued   <= queued + SLOT_W'(1);
            open_len <= '0;
          end
          res_valid <= 1'b1;
          state     <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE) begin
      result.in_range     <= cur.in_range;
      result.cell_index   <= 20'(cur.cell_index);
      result.cell_count   <= r_cnt;
      result.occupancy    <= r_occ;
      result.expired_hits <= r_exp;
      result.log_full     <= r_full;
      result.scans_held   <= 7'((cur.action == ACT_END) ? queued + SLOT_W'(1) : queued);
    end
  end

`ifndef SYNTH
  a_queued_cap: assert property (@(posedge clk) disable iff (rst) queued <= CAP)
    else $error("window queue beyond ring capacity");
  a_open_len: assert property (@(posedge clk) disable iff (rst)
    open_len <= LEN_W'(POINTS_PER_SCAN))
    else $error("open scan log overran");
  a_pop_slot: assert property (@(posedge clk) disable iff (rst) q_pop |-> !res_valid)
    else $error("item taken while result slot occupied");
  a_clear_hold: assert property (@(posedge clk) disable iff (rst) stat.clearing |-> !q_pop)
    else $error("item taken during clearing pass");
  a_done_valid: assert property (@(posedge clk) disable iff (rst) (state == B_DONE) |=> res_valid)
    else $error("result not posted");
`endif

endmodule

/* hdl/sliding_window_occupancy_accumulator_core.sv */
// top level: configuration registers, front end, item queue and back end
//
//  channel | handshake           | payload
//  input   | push / full         | item   (in_t)
//  result  | empty / pop         | result (out_t)
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  front end, one item at a time: accept, subtract, multiply, truncate, row, sum, hand-off
//  back end: in-range point or query reads its count (a point writes it back); others: done
//  a scan expiry reads its length, then per expired hit: log read, count read, count write
//  after reset a clearing pass writes all 1048576 counts, one per cycle, with full high
//  a waiting result holds the back end; the two-entry queue lets the front end run on
`timescale 1ns / 1ps
module sliding_window_occupancy_accumulator_core import swo_acc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         item,
  output logic        empty,
  input  logic        pop,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t       cfg;
  logic       front_ready;
  logic       q_push;
  cls_t       q_wdata;
  logic       q_full;
  logic       q_pop;
  cls_t       q_rdata;
  logic       q_empty;
  back_stat_t stat;
  logic       res_valid;

  assign cfg_ready = 1'b1;
  assign full      = !front_ready || stat.clearing;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width       <= 13'd1024;
      cfg.map_cells       <= 21'd1048576;
      cfg.origin_x        <= '0;
      cfg.origin_y        <= '0;
      cfg.cells_per_meter <= 16'd2560;
      cfg.window_scans    <= 7'd20;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_WIDTH: cfg.map_width       <= cfg_data[12:0];
        REG_MAP_CELLS: cfg.map_cells       <= cfg_data[20:0];
        REG_ORIGIN_X:  cfg.origin_x        <= cfg_data;
        REG_ORIGIN_Y:  cfg.origin_y        <= cfg_data;
        REG_CPM:       cfg.cells_per_meter <= cfg_data[15:0];
        REG_WINDOW:    cfg.window_scans    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  swo_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (push && !full),
    .item   (item),
    .ready  (front_ready),
    .q_push (q_push),
    .q_item (q_wdata),
    .q_full (q_full)
  );

  swo_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  swo_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_item    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .stat      (stat),
    .result    (result),
    .res_valid (res_valid),
    .res_pop   (pop && res_valid)
  );

endmodule
